>>> rtl/text_console_writer_top_assert.svh
// Assertion macros for the text console writer.
// Users must have clk and arst_n in scope where these are expanded.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("text console writer check failed");
// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("text console writer check failed");
`endif

>>> rtl/tcw_pkg.sv
// Shared constants, transaction structs and control codes of the text console writer.
// No dependencies.
`timescale 1ns / 1ps
package tcw_pkg;
	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLUMNS * ROWS;

	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int COLR_W = $clog2(COLUMNS + 8);
	localparam int ROW_W = $clog2(ROWS + 1);
	localparam int LIN_W = $clog2(CELLS + COLUMNS + 1);

	localparam int CMD_W = 2;
	localparam int CHAR_W = 8;
	localparam int COLOR_W = 4;
	localparam int INDEX_W = 11;
	localparam int POS_W = 11;
	localparam int DATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_PUT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BS = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [DATA_W-1:0] BLANK_CELL = 16'h0020;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [CHAR_W-1:0]  char_code;
		logic [COLOR_W-1:0] bg_color;
		logic [COLOR_W-1:0] fg_color;
		logic [INDEX_W-1:0] cell_index;
	} tcw_req_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_position;
		logic [DATA_W-1:0] read_data;
	} tcw_rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] wr_addr;
		logic              printable;
		logic              scroll;
		logic [LIN_W-1:0]  pos_next;
	} tcw_cur_t;
endpackage

>>> rtl/tcw_cell_ram.sv
// Single-port-write, single-port-read cell store with a registered read.
// Depends on tcw_pkg for depth and widths.
`timescale 1ns / 1ps
module tcw_cell_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [tcw_pkg::ADDR_W-1:0] wr_addr,
	input  logic [tcw_pkg::DATA_W-1:0] wr_data,
	input  logic                       re,
	input  logic [tcw_pkg::ADDR_W-1:0] rd_addr,
	output logic [tcw_pkg::DATA_W-1:0] rd_data
);
	logic [tcw_pkg::DATA_W-1:0] mem [tcw_pkg::CELLS];
	logic [tcw_pkg::DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

>>> rtl/tcw_cursor.sv
// Cursor registers and next-position logic for the put and clear commands.
// Depends on tcw_pkg; produces the physical write address from the ring base.
`timescale 1ns / 1ps
module tcw_cursor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       home,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  logic [tcw_pkg::ADDR_W-1:0] base,
	output tcw_pkg::tcw_cur_t          cur
);
	logic [tcw_pkg::COL_W-1:0]  col_q;
	logic [tcw_pkg::ROW_W-1:0]  row_q;
	logic [tcw_pkg::LIN_W-1:0]  lin_q;
	logic [tcw_pkg::COLR_W-1:0] col_ext;
	logic [tcw_pkg::COLR_W-1:0] col_raw;
	logic [tcw_pkg::COLR_W-1:0] tab_sum;
	logic [tcw_pkg::COLR_W-1:0] col_new;
	logic                       row_inc;
	logic                       printable;
	logic [tcw_pkg::ROW_W-1:0]  row_raw;
	logic                       scroll;
	logic [tcw_pkg::ROW_W-1:0]  row_new;
	logic [tcw_pkg::LIN_W-1:0]  lin_raw;
	logic [tcw_pkg::LIN_W-1:0]  lin_new;
	logic [tcw_pkg::ADDR_W:0]   phys_sum;

	always_comb begin
		col_ext = tcw_pkg::COLR_W'(col_q);
		tab_sum = col_ext + tcw_pkg::COLR_W'(8);
		col_raw = col_ext;
		row_inc = 1'b0;
		printable = 1'b0;
		priority if (char_code == tcw_pkg::CH_BS) begin
			if (col_q != '0) begin
				col_raw = col_ext - tcw_pkg::COLR_W'(1);
			end
		end else if (char_code == tcw_pkg::CH_TAB) begin
			col_raw = {tab_sum[tcw_pkg::COLR_W-1:3], 3'b000};
		end else if (char_code == tcw_pkg::CH_CR) begin
			col_raw = '0;
		end else if (char_code == tcw_pkg::CH_LF) begin
			col_raw = '0;
			row_inc = 1'b1;
		end else if (!char_code[tcw_pkg::CHAR_W-1] && char_code >= tcw_pkg::CH_SPACE) begin
			printable = 1'b1;
			col_raw = col_ext + tcw_pkg::COLR_W'(1);
		end else begin
			col_raw = col_ext;
		end

		col_new = col_raw;
		if (col_raw >= tcw_pkg::COLR_W'(tcw_pkg::COLUMNS)) begin
			col_new = '0;
			row_inc = 1'b1;
		end
		row_raw = row_q + tcw_pkg::ROW_W'(row_inc);
		scroll = (row_raw == tcw_pkg::ROW_W'(tcw_pkg::ROWS));
		row_new = scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) : row_raw;

		lin_raw = lin_q - tcw_pkg::LIN_W'(col_q) + tcw_pkg::LIN_W'(col_new)
			+ (row_inc ? tcw_pkg::LIN_W'(tcw_pkg::COLUMNS) : '0);
		lin_new = scroll ? lin_raw - tcw_pkg::LIN_W'(tcw_pkg::COLUMNS) : lin_raw;

		phys_sum = (tcw_pkg::ADDR_W+1)'(lin_q) + (tcw_pkg::ADDR_W+1)'(base);
		if (phys_sum >= (tcw_pkg::ADDR_W+1)'(tcw_pkg::CELLS)) begin
			phys_sum = phys_sum - (tcw_pkg::ADDR_W+1)'(tcw_pkg::CELLS);
		end

		cur.wr_addr = phys_sum[tcw_pkg::ADDR_W-1:0];
		cur.printable = printable;
		cur.scroll = scroll;
		if (home) begin
			cur.pos_next = '0;
		end else if (step) begin
			cur.pos_next = lin_new;
		end else begin
			cur.pos_next = lin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			lin_q <= '0;
		end else if (home) begin
			col_q <= '0;
			row_q <= '0;
			lin_q <= '0;
		end else if (step) begin
			col_q <= col_new[tcw_pkg::COL_W-1:0];
			row_q <= row_new;
			lin_q <= lin_new;
		end
	end
endmodule

>>> rtl/text_console_writer_top.sv
// Top level of the text console writer: command sequencer, row ring and blanking pass.
// Depends on tcw_pkg, tcw_cell_ram, tcw_cursor and text_console_writer_top_assert.svh.
// A transaction accepted in ST_IDLE moves to ST_EXEC; its result is registered into result_q and strobed with done.
// A new transaction is accepted only in ST_IDLE, never while the last one is in ST_EXEC or ST_BLANK.
// A put that scrolls adds a blanking pass of one row; a clear adds a blanking pass of the whole cell memory.
// Reset starts a blanking pass of the cell memory; busy stays high until it ends.
// The receiver cannot stall: each result is shown for exactly one cycle with done high.
`timescale 1ns / 1ps
`include "text_console_writer_top_assert.svh"
module text_console_writer_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tcw_pkg::tcw_req_t request,
	output logic              done,
	output tcw_pkg::tcw_rsp_t result
);
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EXEC  = 3'b010,
		ST_BLANK = 3'b100
	} tcw_state_t;

	tcw_state_t                 state_q;
	tcw_pkg::tcw_req_t          req_s1;
	logic                       in_range_s1;
	logic [tcw_pkg::ADDR_W-1:0] base_q;
	logic [tcw_pkg::ADDR_W-1:0] blank_addr_q;
	logic [tcw_pkg::ADDR_W-1:0] blank_last_q;
	logic                       done_q;
	tcw_pkg::tcw_rsp_t          result_q;

	logic                       accept;
	logic [tcw_pkg::ADDR_W:0]   rd_sum;
	logic [tcw_pkg::ADDR_W:0]   base_sum;
	logic                       ram_we;
	logic [tcw_pkg::ADDR_W-1:0] ram_wr_addr;
	logic [tcw_pkg::DATA_W-1:0] ram_wr_data;
	logic [tcw_pkg::DATA_W-1:0] ram_rd_data;
	logic                       step;
	logic                       home;
	tcw_pkg::tcw_cur_t          cur;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign step = (state_q == ST_EXEC) && (req_s1.command == tcw_pkg::CMD_PUT);
	assign home = (state_q == ST_EXEC) && (req_s1.command == tcw_pkg::CMD_CLEAR);

	always_comb begin
		rd_sum = (tcw_pkg::ADDR_W+1)'(request.cell_index) + (tcw_pkg::ADDR_W+1)'(base_q);
		if (rd_sum >= (tcw_pkg::ADDR_W+1)'(tcw_pkg::CELLS)) begin
			rd_sum = rd_sum - (tcw_pkg::ADDR_W+1)'(tcw_pkg::CELLS);
		end
		base_sum = (tcw_pkg::ADDR_W+1)'(base_q) + (tcw_pkg::ADDR_W+1)'(tcw_pkg::COLUMNS);
		if (base_sum >= (tcw_pkg::ADDR_W+1)'(tcw_pkg::CELLS)) begin
			base_sum = base_sum - (tcw_pkg::ADDR_W+1)'(tcw_pkg::CELLS);
		end
	end

	always_comb begin
		if (state_q == ST_BLANK) begin
			ram_we = 1'b1;
			ram_wr_addr = blank_addr_q;
			ram_wr_data = tcw_pkg::BLANK_CELL;
		end else begin
			ram_we = step && cur.printable;
			ram_wr_addr = cur.wr_addr;
			ram_wr_data = {req_s1.bg_color, req_s1.fg_color, req_s1.char_code};
		end
	end

	tcw_cell_ram u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.re      (accept),
		.rd_addr (rd_sum[tcw_pkg::ADDR_W-1:0]),
		.rd_data (ram_rd_data)
	);

	tcw_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.home      (home),
		.char_code (req_s1.char_code),
		.base      (base_q),
		.cur       (cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BLANK;
			base_q <= '0;
			blank_addr_q <= '0;
			blank_last_q <= tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EXEC);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (home) begin
						state_q <= ST_BLANK;
						base_q <= '0;
						blank_addr_q <= '0;
						blank_last_q <= tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
					end else if (step && cur.scroll) begin
						state_q <= ST_BLANK;
						base_q <= base_sum[tcw_pkg::ADDR_W-1:0];
						blank_addr_q <= base_q;
						blank_last_q <= base_q + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS - 1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_BLANK: begin
					if (blank_addr_q == blank_last_q) begin
						state_q <= ST_IDLE;
					end else begin
						blank_addr_q <= blank_addr_q + tcw_pkg::ADDR_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= request;
			in_range_s1 <= (int'(request.cell_index) < tcw_pkg::CELLS);
		end
		if (state_q == ST_EXEC) begin
			result_q.cursor_position <= cur.pos_next[tcw_pkg::POS_W-1:0];
			if (req_s1.command == tcw_pkg::CMD_READ && in_range_s1) begin
				result_q.read_data <= ram_rd_data;
			end else begin
				result_q.read_data <= '0;
			end
		end
	end

	assign done = done_q;
	assign result = result_q;

	`TCW_ASSERT_NXT(a_accept_to_exec, start && !busy, state_q == ST_EXEC)
	`TCW_ASSERT_NXT(a_exec_gives_done, state_q == ST_EXEC, done)
	`TCW_ASSERT_IMP(a_idle_no_write, state_q == ST_IDLE, !ram_we)
	`TCW_ASSERT_IMP(a_blank_in_bounds, state_q == ST_BLANK, blank_addr_q <= blank_last_q)
	`TCW_ASSERT_IMP(a_pos_in_store, done, int'(result.cursor_position) < tcw_pkg::CELLS)
endmodule

>>> tb/text_console_writer_top_tb.sv
// Self-checking testbench for text_console_writer_top: a directed table, then random commands.
// Results are checked against a table value or a cycle-free model of cell store and cursor.
// Depends on tcw_pkg and the text_console_writer_top RTL.
`timescale 1ns / 1ps
module text_console_writer_top_tb;
	localparam logic [tcw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [tcw_pkg::CHAR_W-1:0] CH_DEL = 8'h7F;
	localparam int RANDOM_ITEMS = 1700;
	localparam int QUIET_TAIL = 200;
	localparam int DIR_STEPS = 25;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		tcw_pkg::tcw_req_t req;
		logic [7:0]        reps;
		logic              typed;
		tcw_pkg::tcw_rsp_t want;
	} dir_step_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	tcw_pkg::tcw_req_t request;
	logic              done;
	tcw_pkg::tcw_rsp_t result;

	logic [tcw_pkg::DATA_W-1:0] console_cells [tcw_pkg::CELLS];
	int cur_col;
	int cur_row;

	tcw_pkg::tcw_rsp_t pending_results [$];
	dir_step_t         dir_steps [DIR_STEPS];

	int mismatches = 0;
	int results_checked = 0;
	int items_sent = 0;
	int reads_sent = 0;
	int clears_sent = 0;
	int scrolls_seen = 0;
	int cycle_count = 0;

	text_console_writer_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic void console_blank();
		for (int i = 0; i < tcw_pkg::CELLS; i++) begin
			console_cells[i] = tcw_pkg::BLANK_CELL;
		end
		cur_col = 0;
		cur_row = 0;
	endfunction

	function automatic void console_put(input logic [tcw_pkg::CHAR_W-1:0] ch,
		input logic [tcw_pkg::COLOR_W-1:0] back, input logic [tcw_pkg::COLOR_W-1:0] fore);
		if (ch == tcw_pkg::CH_BS) begin
			if (cur_col != 0) cur_col--;
		end else if (ch == tcw_pkg::CH_TAB) begin
			cur_col = (cur_col + 8) & ~7;
		end else if (ch == tcw_pkg::CH_CR) begin
			cur_col = 0;
		end else if (ch == tcw_pkg::CH_LF) begin
			cur_col = 0;
			cur_row++;
		end else if (ch >= tcw_pkg::CH_SPACE && ch <= CH_DEL) begin
			console_cells[cur_row * tcw_pkg::COLUMNS + cur_col] = {back, fore, ch};
			cur_col++;
		end
		if (cur_col >= tcw_pkg::COLUMNS) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= tcw_pkg::ROWS) begin
			for (int i = 0; i < (tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS; i++) begin
				console_cells[i] = console_cells[i + tcw_pkg::COLUMNS];
			end
			for (int i = (tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++) begin
				console_cells[i] = tcw_pkg::BLANK_CELL;
			end
			cur_row = tcw_pkg::ROWS - 1;
			scrolls_seen++;
		end
	endfunction

	function automatic tcw_pkg::tcw_rsp_t console_step(input tcw_pkg::tcw_req_t r);
		tcw_pkg::tcw_rsp_t rsp;
		rsp.read_data = '0;
		case (r.command)
			tcw_pkg::CMD_PUT: begin
				console_put(r.char_code, r.bg_color, r.fg_color);
			end
			tcw_pkg::CMD_CLEAR: begin
				console_blank();
			end
			tcw_pkg::CMD_READ: begin
				if (r.cell_index < tcw_pkg::CELLS) rsp.read_data = console_cells[r.cell_index];
			end
			default: begin
			end
		endcase
		rsp.cursor_position = tcw_pkg::POS_W'(cur_row * tcw_pkg::COLUMNS + cur_col);
		return rsp;
	endfunction

	function automatic tcw_pkg::tcw_req_t make_req(input logic [tcw_pkg::CMD_W-1:0] cmd,
		input logic [tcw_pkg::CHAR_W-1:0] ch, input logic [tcw_pkg::COLOR_W-1:0] back,
		input logic [tcw_pkg::COLOR_W-1:0] fore, input logic [tcw_pkg::INDEX_W-1:0] idx);
		tcw_pkg::tcw_req_t r;
		r.command = cmd;
		r.char_code = ch;
		r.bg_color = back;
		r.fg_color = fore;
		r.cell_index = idx;
		return r;
	endfunction

	function automatic tcw_pkg::tcw_rsp_t make_rsp(input logic [tcw_pkg::POS_W-1:0] pos,
		input logic [tcw_pkg::DATA_W-1:0] data);
		tcw_pkg::tcw_rsp_t rsp;
		rsp.cursor_position = pos;
		rsp.read_data = data;
		return rsp;
	endfunction

	function automatic dir_step_t make_step(input tcw_pkg::tcw_req_t r, input int reps,
		input bit typed, input tcw_pkg::tcw_rsp_t want);
		dir_step_t s;
		s.req = r;
		s.reps = 8'(reps);
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	function automatic tcw_pkg::tcw_req_t random_command();
		tcw_pkg::tcw_req_t r;
		int pick;
		int lin;
		r.command = tcw_pkg::CMD_PUT;
		r.char_code = tcw_pkg::CHAR_W'($urandom());
		r.bg_color = tcw_pkg::COLOR_W'($urandom());
		r.fg_color = tcw_pkg::COLOR_W'($urandom());
		r.cell_index = tcw_pkg::INDEX_W'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 1) begin
			r.command = tcw_pkg::CMD_CLEAR;
		end else if (pick < 2) begin
			r.command = CMD_UNUSED;
		end else if (pick < 20) begin
			r.command = tcw_pkg::CMD_READ;
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				lin = cur_row * tcw_pkg::COLUMNS + cur_col - int'($urandom_range(1, 160));
				r.cell_index = tcw_pkg::INDEX_W'((lin < 0) ? 0 : lin);
			end else if (pick < 85) begin
				r.cell_index = tcw_pkg::INDEX_W'($urandom_range(0, tcw_pkg::CELLS - 1));
			end else begin
				r.cell_index = tcw_pkg::INDEX_W'($urandom_range(0, (1 << tcw_pkg::INDEX_W) - 1));
			end
		end else begin
			r.command = tcw_pkg::CMD_PUT;
			pick = $urandom_range(0, 99);
			if (pick < 60) r.char_code = tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CH_SPACE, CH_DEL));
			else if (pick < 70) r.char_code = tcw_pkg::CH_LF;
			else if (pick < 76) r.char_code = tcw_pkg::CH_CR;
			else if (pick < 82) r.char_code = tcw_pkg::CH_TAB;
			else if (pick < 90) r.char_code = tcw_pkg::CH_BS;
			else if (pick < 95) r.char_code = tcw_pkg::CHAR_W'($urandom_range(8'h80, 8'hFF));
			else r.char_code = tcw_pkg::CHAR_W'($urandom_range(0, tcw_pkg::CH_SPACE - 1));
		end
		return r;
	endfunction

	task automatic send_command(input tcw_pkg::tcw_req_t r, input bit typed,
		input tcw_pkg::tcw_rsp_t want);
		tcw_pkg::tcw_rsp_t predicted;
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted = console_step(r);
		pending_results.push_back(typed ? want : predicted);
		items_sent++;
		if (r.command == tcw_pkg::CMD_READ) reads_sent++;
		if (r.command == tcw_pkg::CMD_CLEAR) clears_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no transaction pending", 32'(result), 0);
			end else begin
				if (result.cursor_position !== pending_results[0].cursor_position) begin
					report_mismatch("cursor_position", 32'(result.cursor_position),
						32'(pending_results[0].cursor_position));
				end
				if (result.read_data !== pending_results[0].read_data) begin
					report_mismatch("read_data", 32'(result.read_data),
						32'(pending_results[0].read_data));
				end
				void'(pending_results.pop_front());
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, pending_results.size());
			$display("text_console_writer_top regression: fail");
			$finish;
		end
	end

	initial begin
		tcw_pkg::tcw_req_t r;
		bit idling;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		idling = 1'b1;
		console_blank();

		dir_steps[0] = make_step(make_req(tcw_pkg::CMD_READ, 0, 0, 0, 0), 1, 1,
			make_rsp(0, tcw_pkg::BLANK_CELL));
		dir_steps[1] = make_step(make_req(tcw_pkg::CMD_READ, 0, 0, 0,
			tcw_pkg::INDEX_W'(tcw_pkg::CELLS - 1)), 1, 1, make_rsp(0, tcw_pkg::BLANK_CELL));
		dir_steps[2] = make_step(make_req(tcw_pkg::CMD_READ, 0, 0, 0,
			tcw_pkg::INDEX_W'(tcw_pkg::CELLS)), 1, 1, make_rsp(0, 0));
		dir_steps[3] = make_step(make_req(tcw_pkg::CMD_READ, 0, 0, 0, 11'h7FF), 1, 1,
			make_rsp(0, 0));
		dir_steps[4] = make_step(make_req(CMD_UNUSED, 8'hFF, 4'hF, 4'hF, 11'h7FF), 1, 1,
			make_rsp(0, 0));
		dir_steps[5] = make_step(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 0, 0, 0), 1, 1,
			make_rsp(0, 0));
		dir_steps[6] = make_step(make_req(tcw_pkg::CMD_PUT, 8'h80, 4'hF, 4'hF, 0), 1, 1,
			make_rsp(0, 0));
		dir_steps[7] = make_step(make_req(tcw_pkg::CMD_PUT, 8'hFF, 4'hF, 4'hF, 0), 1, 1,
			make_rsp(0, 0));
		dir_steps[8] = make_step(make_req(tcw_pkg::CMD_PUT, 8'h00, 0, 0, 0), 1, 1,
			make_rsp(0, 0));
		dir_steps[9] = make_step(make_req(tcw_pkg::CMD_PUT, 8'h1F, 0, 0, 0), 1, 1,
			make_rsp(0, 0));
		dir_steps[10] = make_step(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_SPACE, 0, 0, 0), 1, 1,
			make_rsp(1, 0));
		dir_steps[11] = make_step(make_req(tcw_pkg::CMD_PUT, CH_DEL, 4'hF, 4'hF, 0), 1, 1,
			make_rsp(2, 0));
		dir_steps[12] = make_step(make_req(tcw_pkg::CMD_READ, 0, 0, 0, 0), 1, 1,
			make_rsp(2, 16'h0020));
		dir_steps[13] = make_step(make_req(tcw_pkg::CMD_READ, 0, 0, 0, 1), 1, 1,
			make_rsp(2, 16'hFF7F));
		dir_steps[14] = make_step(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 0, 0, 0), 1, 0,
			'0);
		dir_steps[15] = make_step(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 0, 0, 0), 10, 0,
			'0);
		dir_steps[16] = make_step(make_req(tcw_pkg::CMD_PUT, 8'h71, 4'h3, 4'hC, 0), 1, 0, '0);
		dir_steps[17] = make_step(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_CR, 0, 0, 0), 1, 0,
			'0);
		dir_steps[18] = make_step(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_LF, 0, 0, 0), 30, 0,
			'0);
		dir_steps[19] = make_step(make_req(tcw_pkg::CMD_PUT, 8'h41, 4'h5, 4'hA, 0), 85, 0, '0);
		dir_steps[20] = make_step(make_req(tcw_pkg::CMD_READ, 0, 0, 0,
			tcw_pkg::INDEX_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS)), 1, 0, '0);
		dir_steps[21] = make_step(make_req(tcw_pkg::CMD_READ, 0, 0, 0,
			tcw_pkg::INDEX_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS - 1)), 1, 0, '0);
		dir_steps[22] = make_step(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 0, 0, 0), 1, 0,
			'0);
		dir_steps[23] = make_step(make_req(tcw_pkg::CMD_CLEAR, 0, 0, 0, 0), 1, 1,
			make_rsp(0, 0));
		dir_steps[24] = make_step(make_req(tcw_pkg::CMD_READ, 0, 0, 0,
			tcw_pkg::INDEX_W'(tcw_pkg::CELLS - 1)), 1, 1, make_rsp(0, tcw_pkg::BLANK_CELL));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_steps[i]) begin
			for (int k = 0; k < dir_steps[i].reps; k++) begin
				send_command(dir_steps[i].req, dir_steps[i].typed, dir_steps[i].want);
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) idling = ($urandom_range(0, 2) != 0);
			if (n == RANDOM_ITEMS / 2) begin
				start <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end else if (idling && n < RANDOM_ITEMS - QUIET_TAIL &&
				$urandom_range(0, 2) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			r = random_command();
			send_command(r, 1'b0, '0);
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions (%0d reads, %0d clears); checked %0d results.",
			items_sent, reads_sent, clears_sent, results_checked);
		$display("The cursor scrolled the screen %0d times; %0d mismatches were found.",
			scrolls_seen, mismatches);
		if (mismatches == 0) begin
			$display("text_console_writer_top regression: pass");
		end else begin
			$display("text_console_writer_top regression: fail");
		end
		$finish;
	end
endmodule
